### sv/mandelbrot_escape_time_pen_top_macros.svh
// assertion helpers for the escape-time block
`ifndef MANDELBROT_ESCAPE_TIME_PEN_TOP_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PEN_TOP_MACROS_SVH

// checked only outside reset
`define METP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define METP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### sv/metp_pkg.sv
`timescale 1ns / 1ps
package metp_pkg;

   localparam int FRAC_BITS  = 28;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITERATIONS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_LIMIT   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_DEPTH    = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PEN_BASE       = 8'd3;

   localparam logic [15:0] MAX_ITERATIONS_RST = 16'd256;
   localparam logic [30:0] ESCAPE_LIMIT_RST   = 31'd536870912;
   localparam logic [3:0]  PLANE_DEPTH_RST    = 4'd4;
   localparam logic [7:0]  PEN_BASE_RST       = 8'd6;

   typedef struct packed {
      logic signed [31:0] c_real;
      logic signed [31:0] c_imag;
   } req_type;

   typedef struct packed {
      logic [15:0] iteration_count;
      logic        escaped;
      logic [7:0]  pen;
   } rsp_type;

   typedef struct packed {
      logic [15:0] max_iterations;
      logic [30:0] escape_limit;
      logic [3:0]  plane_depth;
      logic [7:0]  pen_base;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } core_status_type;

endpackage

### sv/metp_mul.sv
`timescale 1ns / 1ps
module metp_mul
   import metp_pkg::*;
(
   input  logic signed [31:0] op_a,
   input  logic signed [31:0] op_b,
   output logic signed [63:0] product
);

   assign product = op_a * op_b;

endmodule

### sv/metp_core.sv
`timescale 1ns / 1ps
module metp_core
   import metp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            start,
   input  req_type         req_data,
   input  logic            out_free,
   output core_status_type status,
   output rsp_type         result
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LIM  = 3'd1;
   localparam logic [2:0] ST_CRS  = 3'd2;
   localparam logic [2:0] ST_UPD  = 3'd3;
   localparam logic [2:0] ST_SQR  = 3'd4;
   localparam logic [2:0] ST_SQI  = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic signed [31:0] cr_ff, cr_in, ci_ff, ci_in;
   logic signed [31:0] zr_ff, zr_in, zi_ff, zi_in;
   logic signed [63:0] sq_r_ff, sq_r_in, sq_i_ff, sq_i_in;
   logic signed [63:0] cross_ff, cross_in;
   logic [61:0]        lim2_ff, lim2_in;
   logic [15:0]        n_ff, n_in;
   logic [14:0]        res_ff, res_in;
   logic [14:0]        span_ff, span_in;
   logic               esc_ff, esc_in;

   logic signed [31:0] op_a, op_b;
   logic signed [63:0] product;

   logic signed [16:0] colors_raw;
   logic [14:0]        colors;
   logic [14:0]        span;
   logic [63:0]        mag;
   logic signed [63:0] diff;
   logic signed [35:0] re_sh;
   logic signed [36:0] im_sh;
   logic signed [36:0] re_sum;
   logic signed [37:0] im_sum;
   logic signed [31:0] re_sat, im_sat;
   logic [14:0]        res_inc;

   metp_mul u_mul (
      .op_a    (op_a),
      .op_b    (op_b),
      .product (product)
   );

   // multiplier operand selection
   always_comb begin
      case (state_ff)
         ST_LIM: begin
            op_a = signed'({1'b0, cfg.escape_limit});
            op_b = signed'({1'b0, cfg.escape_limit});
         end
         ST_CRS: begin
            op_a = zr_ff;
            op_b = zi_ff;
         end
         ST_SQI: begin
            op_a = zi_ff;
            op_b = zi_ff;
         end
         default: begin
            op_a = zr_ff;
            op_b = zr_ff;
         end
      endcase
   end

   // colour span for the pen residue
   always_comb begin
      colors_raw = (17'sd1 <<< cfg.plane_depth) - signed'({9'd0, cfg.pen_base}) - 17'sd1;
      if (colors_raw < 17'sd1) begin
         colors = 15'd1;
      end else begin
         colors = colors_raw[14:0];
      end
      if ({1'b0, cfg.max_iterations} < {2'b00, colors}) begin
         span = cfg.max_iterations[14:0];
      end else begin
         span = colors;
      end
   end

   // step arithmetic with floor shifts and saturation
   always_comb begin
      mag    = 64'(sq_r_ff[62:0]) + 64'(sq_i_ff[62:0]);
      diff   = sq_r_ff - sq_i_ff;
      re_sh  = diff[63:FRAC_BITS];
      im_sh  = cross_ff[63:FRAC_BITS-1];
      re_sum = {re_sh[35], re_sh} + {{5{cr_ff[31]}}, cr_ff};
      im_sum = {im_sh[36], im_sh} + {{6{ci_ff[31]}}, ci_ff};
      if (re_sum[36:31] == {6{re_sum[31]}}) begin
         re_sat = re_sum[31:0];
      end else if (re_sum[36]) begin
         re_sat = 32'sh8000_0000;
      end else begin
         re_sat = 32'sh7fff_ffff;
      end
      if (im_sum[37:31] == {7{im_sum[31]}}) begin
         im_sat = im_sum[31:0];
      end else if (im_sum[37]) begin
         im_sat = 32'sh8000_0000;
      end else begin
         im_sat = 32'sh7fff_ffff;
      end
      res_inc = res_ff + 15'd1;
   end

   always_comb begin
      state_in = state_ff;
      cr_in    = cr_ff;
      ci_in    = ci_ff;
      zr_in    = zr_ff;
      zi_in    = zi_ff;
      sq_r_in  = sq_r_ff;
      sq_i_in  = sq_i_ff;
      cross_in = cross_ff;
      lim2_in  = lim2_ff;
      n_in     = n_ff;
      res_in   = res_ff;
      span_in  = span_ff;
      esc_in   = esc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cr_in    = req_data.c_real;
               ci_in    = req_data.c_imag;
               state_in = ST_LIM;
            end
         end
         ST_LIM: begin
            lim2_in  = product[61:0];
            zr_in    = '0;
            zi_in    = '0;
            sq_r_in  = '0;
            sq_i_in  = '0;
            n_in     = '0;
            res_in   = '0;
            span_in  = span;
            esc_in   = 1'b0;
            state_in = ST_CRS;
         end
         ST_CRS: begin
            if (mag > 64'(lim2_ff)) begin
               esc_in   = 1'b1;
               state_in = ST_DONE;
            end else if (n_ff == cfg.max_iterations) begin
               state_in = ST_DONE;
            end else begin
               cross_in = product;
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            zr_in = re_sat;
            zi_in = im_sat;
            n_in  = n_ff + 16'd1;
            if (n_ff == 16'd0 || res_inc == span_ff) begin
               res_in = '0;
            end else begin
               res_in = res_inc;
            end
            state_in = ST_SQR;
         end
         ST_SQR: begin
            sq_r_in  = product;
            state_in = ST_SQI;
         end
         ST_SQI: begin
            sq_i_in  = product;
            state_in = ST_CRS;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cr_ff    <= cr_in;
      ci_ff    <= ci_in;
      zr_ff    <= zr_in;
      zi_ff    <= zi_in;
      sq_r_ff  <= sq_r_in;
      sq_i_ff  <= sq_i_in;
      cross_ff <= cross_in;
      lim2_ff  <= lim2_in;
      n_ff     <= n_in;
      res_ff   <= res_in;
      span_ff  <= span_in;
      esc_ff   <= esc_in;
   end

   always_comb begin
      status.busy = (state_ff != ST_IDLE);
      status.done = (state_ff == ST_DONE) && out_free;
      result.escaped = esc_ff;
      if (esc_ff) begin
         result.iteration_count = n_ff - 16'd1;
         result.pen             = cfg.pen_base + res_ff[7:0] + 8'd1;
      end else begin
         result.iteration_count = n_ff;
         result.pen             = cfg.pen_base;
      end
   end

endmodule

### sv/mandelbrot_escape_time_pen_top.sv
// Escape-time evaluator: each req_ word is one point c in signed Q4.28 and gives one rsp_
// word with the iteration count, an escape flag and a pen number. A single 32x32 signed
// multiplier is shared for every product, so one step of z = z*z + c runs through a
// cross product, an update and two squares in turn. The block takes one point at a time;
// req_stall stays high from acceptance until the block is back in idle. The finished word
// sits in an output register, and the block holds its result until that register has room.
// The user must write registers over csr_ only while no point is in flight and no word is
// waiting; the block itself does not enforce this.
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_pen_top_macros.svh"
module mandelbrot_escape_time_pen_top
   import metp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type         cfg_ff, cfg_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;
   core_status_type core_status;
   rsp_type         core_result;
   logic            out_free;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = core_status.busy;

   metp_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .start    (req_valid && !core_status.busy),
      .req_data (req_data),
      .out_free (out_free),
      .status   (core_status),
      .result   (core_result)
   );

   // register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAX_ITERATIONS: cfg_in.max_iterations = csr_data[15:0];
            CSR_ESCAPE_LIMIT:   cfg_in.escape_limit   = csr_data[30:0];
            CSR_PLANE_DEPTH:    cfg_in.plane_depth    = csr_data[3:0];
            CSR_PEN_BASE:       cfg_in.pen_base       = csr_data[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // output word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (core_status.done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_iterations <= MAX_ITERATIONS_RST;
         cfg_ff.escape_limit   <= ESCAPE_LIMIT_RST;
         cfg_ff.plane_depth    <= PLANE_DEPTH_RST;
         cfg_ff.pen_base       <= PEN_BASE_RST;
         rsp_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `METP_ASSERT(a_busy_after_accept, req_valid && !req_stall |=> req_stall, "block not busy after taking a point")
   `METP_ASSERT(a_inside_word, rsp_valid && !rsp_data.escaped |-> rsp_data.pen == cfg_ff.pen_base && rsp_data.iteration_count == cfg_ff.max_iterations, "inside point with wrong pen or count")
   `METP_ASSERT(a_escape_count, rsp_valid && rsp_data.escaped |-> rsp_data.iteration_count < cfg_ff.max_iterations, "escape count at or beyond the limit")
   `METP_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid && !req_stall, "block not idle after reset")

endmodule

### bench/mandelbrot_escape_time_pen_top_test.sv
`timescale 1ns / 1ps
module mandelbrot_escape_time_pen_top_test;
   import metp_pkg::*;

   localparam int Q_ONE = 1 << FRAC_BITS;
   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
   localparam logic [30:0] LIMIT_MAX = 31'h7FFF_FFFF;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED = CSR_PEN_BASE + 1'b1;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   cfg_type regs_now = '{MAX_ITERATIONS_RST, ESCAPE_LIMIT_RST, PLANE_DEPTH_RST, PEN_BASE_RST};
   req_type points_to_send[$];
   rsp_type outcomes_due[$];
   rsp_type outcome_want;
   bit req_taken = 1'b0;
   int req_gap = 0;
   int req_quiet = 0;
   int rsp_hold = 0;
   int rsp_quiet = 0;
   int mismatches = 0;

   mandelbrot_escape_time_pen_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic longint sat_q428(longint v);
      if (v > longint'(Q_MAX)) return longint'(Q_MAX);
      if (v < longint'(Q_MIN)) return longint'(Q_MIN);
      return v;
   endfunction

   function automatic rsp_type predict_escape(req_type pt, cfg_type cf);
      longint zr, zi, re, im, colors, span;
      logic [63:0] mag_r, mag_i, lim_sq;
      int steps;
      bit gone;
      rsp_type res;
      zr = 0;
      zi = 0;
      steps = 0;
      gone = 1'b0;
      lim_sq = 64'(cf.escape_limit) * 64'(cf.escape_limit);
      while (steps < int'(cf.max_iterations) && !gone) begin
         re = ((zr * zr - zi * zi) >>> FRAC_BITS) + longint'($signed(pt.c_real));
         im = ((zr * zi) >>> (FRAC_BITS - 1)) + longint'($signed(pt.c_imag));
         zr = sat_q428(re);
         zi = sat_q428(im);
         mag_r = (zr < 0) ? -zr : zr;
         mag_i = (zi < 0) ? -zi : zi;
         if (mag_r * mag_r + mag_i * mag_i > lim_sq) gone = 1'b1;
         else steps++;
      end
      colors = (longint'(1) << cf.plane_depth) - longint'(cf.pen_base) - 1;
      if (colors < 1) colors = 1;
      span = (longint'(cf.max_iterations) < colors) ? longint'(cf.max_iterations) : colors;
      res.iteration_count = 16'(steps);
      res.escaped = gone;
      if (gone) res.pen = 8'((longint'(steps) % span) + longint'(cf.pen_base) + 1);
      else res.pen = cf.pen_base;
      return res;
   endfunction

   // mostly short gaps, a few long ones, now and then a calm stretch
   function automatic int pick_gap(inout int quiet);
      int r;
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         quiet = $urandom_range(20, 80);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [31:0] pick_extreme();
      case ($urandom_range(0, 4))
         0: return Q_MIN;
         1: return Q_MAX;
         2: return 32'sd0;
         3: return -32'sd1;
         default: return 32'sd1;
      endcase
   endfunction

   function automatic req_type rand_point();
      req_type pt;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         // window around the set: real -2.25..0.75, imag -1.5..1.5
         pt.c_real = $urandom_range(0, 3 * Q_ONE) - (9 * Q_ONE / 4);
         pt.c_imag = $urandom_range(0, 3 * Q_ONE) - (3 * Q_ONE / 2);
      end else if (pick < 82) begin
         pt.c_real = $urandom;
         pt.c_imag = $urandom;
      end else if (pick < 92) begin
         pt.c_real = pick_extreme();
         pt.c_imag = pick_extreme();
      end else begin
         pt.c_real = $urandom_range(0, 4 * Q_ONE) - 2 * Q_ONE;
         pt.c_imag = $urandom_range(0, 4 * Q_ONE) - 2 * Q_ONE;
      end
      return pt;
   endfunction

   function automatic void push_point(logic [31:0] re, logic [31:0] im);
      req_type pt;
      pt.c_real = re;
      pt.c_imag = im;
      points_to_send.push_back(pt);
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      logic [CSR_DATA_W-1:0] word;
      word = $urandom;
      case (idx)
         CSR_MAX_ITERATIONS: word[15:0] = val[15:0];
         CSR_ESCAPE_LIMIT:   word[30:0] = val[30:0];
         CSR_PLANE_DEPTH:    word[3:0] = val[3:0];
         CSR_PEN_BASE:       word[7:0] = val[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= word;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_MAX_ITERATIONS: regs_now.max_iterations = word[15:0];
         CSR_ESCAPE_LIMIT:   regs_now.escape_limit = word[30:0];
         CSR_PLANE_DEPTH:    regs_now.plane_depth = word[3:0];
         CSR_PEN_BASE:       regs_now.pen_base = word[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [15:0] mi, input logic [30:0] lim,
                             input logic [3:0] depth, input logic [7:0] base);
      write_reg(CSR_MAX_ITERATIONS, 32'(mi));
      write_reg(CSR_ESCAPE_LIMIT, 32'(lim));
      write_reg(CSR_PLANE_DEPTH, 32'(depth));
      write_reg(CSR_PEN_BASE, 32'(base));
      if ($urandom_range(0, 1))
         write_reg(CSR_IDX_W'($urandom_range(CSR_FIRST_UNUSED, {CSR_IDX_W{1'b1}})), $urandom);
   endtask

   task automatic drain();
      while (points_to_send.size() > 0 || req_valid || outcomes_due.size() > 0)
         @(negedge clock);
   endtask

   // driver
   always @(negedge clock) begin
      if (!reset && !(req_valid && !req_taken)) begin
         req_taken = 1'b0;
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap--;
         end else if (points_to_send.size() > 0) begin
            req_data <= points_to_send.pop_front();
            req_valid <= 1'b1;
            req_gap = pick_gap(req_quiet);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold--;
      end else begin
         rsp_stall <= 1'b0;
         rsp_hold = pick_gap(rsp_quiet);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            outcomes_due.push_back(predict_escape(req_data, regs_now));
            req_taken = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (outcomes_due.size() == 0) begin
               $display("%0t: result with nothing expected, count %0d escaped %0d pen %0d",
                        $time, rsp_data.iteration_count, rsp_data.escaped, rsp_data.pen);
               mismatches++;
            end else begin
               outcome_want = outcomes_due.pop_front();
               if (rsp_data.iteration_count !== outcome_want.iteration_count) begin
                  $display("%0t: iteration_count expected %0d actual %0d", $time,
                           outcome_want.iteration_count, rsp_data.iteration_count);
                  mismatches++;
               end
               if (rsp_data.escaped !== outcome_want.escaped) begin
                  $display("%0t: escaped expected %0d actual %0d", $time,
                           outcome_want.escaped, rsp_data.escaped);
                  mismatches++;
               end
               if (rsp_data.pen !== outcome_want.pen) begin
                  $display("%0t: pen expected %0d actual %0d", $time,
                           outcome_want.pen, rsp_data.pen);
                  mismatches++;
               end
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int ph;
      int k;
      int mag_a;
      int mag_b;
      logic [15:0] mi;
      logic [30:0] lim;
      logic [7:0] base;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed points at reset settings
      push_point(0, 0);
      push_point(Q_MAX, Q_MAX);
      push_point(Q_MIN, Q_MIN);
      push_point(Q_MAX, Q_MIN);
      push_point(Q_MIN, Q_MAX);
      push_point(0, Q_MAX);
      push_point(Q_MAX, 0);
      push_point(0, Q_MIN);
      push_point(Q_MIN, 0);
      push_point(-2 * Q_ONE, 0);                       // sits on the escape radius
      push_point(Q_ONE / 4, 0);                        // cusp
      push_point(-3 * Q_ONE / 4, Q_ONE / 20);
      push_point(-Q_ONE, 0);
      push_point(0, Q_ONE);
      push_point(0, -Q_ONE);
      push_point(Q_ONE / 2, Q_ONE / 2);
      push_point(-7 * Q_ONE / 4, 0);
      push_point(-Q_ONE / 10, 174751482);
      push_point(-5 * Q_ONE / 4, Q_ONE / 10);
      push_point(-1, 1);
      drain();

      // zero iteration limit
      set_config(16'd0, ESCAPE_LIMIT_RST, 4'd0, 8'd0);
      for (k = 0; k < 8; k++) points_to_send.push_back(rand_point());
      drain();

      // widest limits, pen wrap; only points that leave at once plus one saturated point
      set_config(16'hFFFF, LIMIT_MAX, 4'd15, 8'd255);
      push_point(Q_MIN, Q_MIN);
      for (k = 0; k < 10; k++) begin
         mag_a = $urandom_range(1610612736, 32'h7FFF_FFFF);
         mag_b = $urandom_range(1610612736, 32'h7FFF_FFFF);
         push_point($urandom_range(0, 1) ? -mag_a : mag_a, $urandom_range(0, 1) ? -mag_b : mag_b);
      end
      push_point(Q_MAX, 0);
      drain();

      for (ph = 0; ph < 13; ph++) begin
         mi = (ph == 0) ? 16'd1 : (ph == 1) ? 16'd64 : 16'($urandom_range(1, 64));
         case ($urandom_range(0, 9))
            0: lim = '0;
            1: lim = LIMIT_MAX;
            2, 3: lim = 31'($urandom);
            default: lim = ESCAPE_LIMIT_RST;
         endcase
         if (ph == 0) lim = LIMIT_MAX;
         if (ph == 1) lim = '0;
         base = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
         set_config(mi, lim, 4'($urandom_range(0, 15)), base);
         for (k = 0; k < 100; k++) points_to_send.push_back(rand_point());
         drain();
      end

      repeat (40) @(posedge clock);
      if (mismatches == 0 && outcomes_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
